/* sv/rei_pkg.sv */
// Shared types and constants for the ray/ellipsoid intersection pipeline.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none
package rei_pkg;

    localparam int unsigned ENTRY_W = 21;
    localparam int unsigned CFG_W   = 63;
    localparam int unsigned IDX_W   = 3;

    localparam logic [IDX_W-1:0] CFG_ROW_X    = 3'd0;
    localparam logic [IDX_W-1:0] CFG_ROW_Y    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_ROW_Z    = 3'd2;
    localparam logic [IDX_W-1:0] CFG_CENTER_X = 3'd3;
    localparam logic [IDX_W-1:0] CFG_CENTER_Y = 3'd4;
    localparam logic [IDX_W-1:0] CFG_CENTER_Z = 3'd5;

    // 1.0 with 32 fraction bits.
    localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;

    typedef enum logic [1:0] {
        ST_HIT   = 2'd0,
        ST_MISS  = 2'd1,
        ST_DEGEN = 2'd2
    } t_status;

    // Per-ray values that ride alongside the square root.
    typedef struct packed {
        t_status     status;
        logic        hneg;
        logic [63:0] hm;
        logic [63:0] a;
    } t_side;

endpackage
`default_nettype wire

/* sv/rei_xform.sv */
// Centre subtraction and matrix transform into unit-sphere space (3 stages).
// Depends on rei_pkg.
`default_nettype none
module rei_xform (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire logic                                  i_valid,
    input  wire logic [2:0][31:0]                      i_origin,
    input  wire logic [2:0][31:0]                      i_dir,
    input  wire logic [2:0][rei_pkg::CFG_W-1:0]        i_rows,
    input  wire logic [2:0][31:0]                      i_ctr,
    output logic                                       o_valid,
    output logic [2:0][31:0]                           o_eo,
    output logic [2:0][31:0]                           o_ed
);

    logic [2:0]         r_vld;
    logic signed [32:0] r1_rel [3];
    logic signed [31:0] r1_dir [3];
    logic signed [53:0] r2_po  [3][3];
    logic signed [53:0] r2_pd  [3][3];
    logic [2:0][31:0]   r3_eo;
    logic [2:0][31:0]   r3_ed;

    function automatic logic signed [20:0] entry(input logic [rei_pkg::CFG_W-1:0] row,
                                                 input int unsigned col);
        return $signed(row[rei_pkg::ENTRY_W*col +: rei_pkg::ENTRY_W]);
    endfunction

    // Round half up from 32 fraction bits to 16, then clamp to 32 bits.
    function automatic logic [31:0] rnd_sat(input logic signed [55:0] v);
        logic signed [55:0] r;
        logic signed [39:0] q;
        r = v + 56'sd32768;
        q = r[55:16];
        if (q > 40'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (q < -40'sd2147483648) begin
            return 32'h8000_0000;
        end
        return q[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [55:0] so;
        logic signed [55:0] sd;
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_rel[i] <= $signed({i_origin[i][31], i_origin[i]})
                           - $signed({i_ctr[i][31], i_ctr[i]});
                r1_dir[i] <= $signed(i_dir[i]);
            end
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r2_po[i][j] <= r1_rel[j] * entry(i_rows[i], j);
                    r2_pd[i][j] <= r1_dir[j] * entry(i_rows[i], j);
                end
            end
            for (int i = 0; i < 3; i++) begin
                so = r2_po[i][0] + r2_po[i][1] + r2_po[i][2];
                sd = r2_pd[i][0] + r2_pd[i][1] + r2_pd[i][2];
                r3_eo[i] <= rnd_sat(so);
                r3_ed[i] <= rnd_sat(sd);
            end
        end
    end

    assign o_valid = r_vld[2];
    assign o_eo    = r3_eo;
    assign o_ed    = r3_ed;

endmodule
`default_nettype wire

/* sv/rei_quad.sv */
// Quadratic terms a, h, c and the 128-bit discriminant h*h - a*c (5 stages).
// Depends on rei_pkg.
`default_nettype none
module rei_quad (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [2:0][31:0]  i_eo,
    input  wire logic [2:0][31:0]  i_ed,
    output logic                   o_valid,
    output logic [127:0]           o_disc,
    output rei_pkg::t_side         o_side
);

    logic [4:0]         r_vld;
    logic signed [63:0] r4_dd [3];
    logic signed [63:0] r4_oo [3];
    logic signed [63:0] r4_od [3];

    logic [63:0]        r5_a, r5_hm, r5_cm;
    logic               r5_hneg, r5_cneg;

    logic [63:0]        r6_hp [4];
    logic [63:0]        r6_cp [4];
    logic [63:0]        r6_a, r6_hm;
    logic               r6_hneg, r6_cneg;

    logic [127:0]       r7_hsq, r7_ac;
    logic [63:0]        r7_a, r7_hm;
    logic               r7_hneg, r7_cneg;

    logic [127:0]       r8_disc;
    rei_pkg::t_side     r8_side;

    // Partial products are indexed {high x, high y}: 0 low*low, 1 low*high,
    // 2 high*low, 3 high*high. The sum wraps at 128 bits.
    function automatic logic [127:0] join4(input logic [63:0] p0, input logic [63:0] p1,
                                           input logic [63:0] p2, input logic [63:0] p3);
        return {p3, 64'h0} + {32'h0, p1, 32'h0} + {32'h0, p2, 32'h0} + {64'h0, p0};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        logic [63:0]        asum, qsum;
        logic signed [65:0] hs;
        logic [65:0]        hmag;
        logic               cn;
        logic               lt;
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r4_dd[i] <= $signed(i_ed[i]) * $signed(i_ed[i]);
                r4_oo[i] <= $signed(i_eo[i]) * $signed(i_eo[i]);
                r4_od[i] <= $signed(i_eo[i]) * $signed(i_ed[i]);
            end

            asum = r4_dd[0] + r4_dd[1] + r4_dd[2];
            qsum = r4_oo[0] + r4_oo[1] + r4_oo[2];
            hs   = r4_od[0] + r4_od[1] + r4_od[2];
            hmag = hs[65] ? -hs : hs;
            cn   = qsum < rei_pkg::ONE_Q32;
            r5_a    <= asum;
            r5_hneg <= hs[65];
            r5_hm   <= hmag[63:0];
            r5_cneg <= cn;
            r5_cm   <= cn ? rei_pkg::ONE_Q32 - qsum : qsum - rei_pkg::ONE_Q32;

            r6_hp[0] <= r5_hm[31:0]  * r5_hm[31:0];
            r6_hp[1] <= r5_hm[31:0]  * r5_hm[63:32];
            r6_hp[2] <= r5_hm[63:32] * r5_hm[31:0];
            r6_hp[3] <= r5_hm[63:32] * r5_hm[63:32];
            r6_cp[0] <= r5_a[31:0]   * r5_cm[31:0];
            r6_cp[1] <= r5_a[31:0]   * r5_cm[63:32];
            r6_cp[2] <= r5_a[63:32]  * r5_cm[31:0];
            r6_cp[3] <= r5_a[63:32]  * r5_cm[63:32];
            r6_a    <= r5_a;
            r6_hm   <= r5_hm;
            r6_hneg <= r5_hneg;
            r6_cneg <= r5_cneg;

            r7_hsq  <= join4(r6_hp[0], r6_hp[1], r6_hp[2], r6_hp[3]);
            r7_ac   <= join4(r6_cp[0], r6_cp[1], r6_cp[2], r6_cp[3]);
            r7_a    <= r6_a;
            r7_hm   <= r6_hm;
            r7_hneg <= r6_hneg;
            r7_cneg <= r6_cneg;

            lt = r7_hsq < r7_ac;
            r8_disc      <= r7_cneg ? r7_hsq + r7_ac : r7_hsq - r7_ac;
            r8_side.a    <= r7_a;
            r8_side.hm   <= r7_hm;
            r8_side.hneg <= r7_hneg;
            if (r7_a == 64'h0) begin
                r8_side.status <= rei_pkg::ST_DEGEN;
            end else if (!r7_cneg && lt) begin
                r8_side.status <= rei_pkg::ST_MISS;
            end else begin
                r8_side.status <= rei_pkg::ST_HIT;
            end
        end
    end

    assign o_valid = r_vld[4];
    assign o_disc  = r8_disc;
    assign o_side  = r8_side;

endmodule
`default_nettype wire

/* sv/rei_sqrt.sv */
// Pipelined floor square root of a 128-bit value, one root bit per stage.
// Depends on rei_pkg for the side-band record.
`default_nettype none
module rei_sqrt (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [127:0]    i_disc,
    input  wire rei_pkg::t_side  i_side,
    output logic                 o_valid,
    output logic [63:0]          o_root,
    output rei_pkg::t_side       o_side
);

    localparam int unsigned NSTG = 64;

    typedef struct packed {
        logic [66:0]    rem;
        logic [63:0]    root;
        logic [127:0]   rest;
        rei_pkg::t_side side;
    } t_sq;

    logic [NSTG-1:0] r_vld;
    t_sq             r_st [NSTG];

    // Bring down the next two radicand bits and try the next root bit.
    function automatic t_sq step(input t_sq s);
        t_sq         o;
        logic [66:0] cur;
        logic [66:0] trial;
        o     = s;
        cur   = {s.rem[64:0], s.rest[127:126]};
        trial = {1'b0, s.root, 2'b01};
        if (cur >= trial) begin
            o.rem  = cur - trial;
            o.root = {s.root[62:0], 1'b1};
        end else begin
            o.rem  = cur;
            o.root = {s.root[62:0], 1'b0};
        end
        o.rest = {s.rest[125:0], 2'b00};
        return o;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        t_sq init;
        init.rem  = '0;
        init.root = '0;
        init.rest = i_disc;
        init.side = i_side;
        if (i_en) begin
            r_st[0] <= step(init);
            for (int k = 1; k < NSTG; k++) begin
                r_st[k] <= step(r_st[k-1]);
            end
        end
    end

    assign o_valid = r_vld[NSTG-1];
    assign o_root  = r_st[NSTG-1].root;
    assign o_side  = r_st[NSTG-1].side;

endmodule
`default_nettype wire

/* sv/rei_div.sv */
// Numerator -h - sqrt(D), pipelined 32-step restoring divide by a,
// and saturation to Q16.16. Depends on rei_pkg.
`default_nettype none
module rei_div (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [63:0]     i_root,
    input  wire rei_pkg::t_side  i_side,
    output logic                 o_valid,
    output logic [31:0]          o_hit_param,
    output rei_pkg::t_status     o_status
);

    localparam int unsigned NSTEP = 32;

    typedef struct packed {
        logic [63:0]      rem;
        logic [31:0]      low;
        logic [31:0]      quo;
        logic             ovf;
        logic             nneg;
        logic [63:0]      a;
        rei_pkg::t_status status;
    } t_dv;

    logic [NSTEP+1:0] r_vld;
    t_dv              r_st [NSTEP+1];
    logic [31:0]      r_hit;
    rei_pkg::t_status r_status;

    function automatic t_dv step(input t_dv s);
        t_dv         o;
        logic [64:0] cur;
        o   = s;
        cur = {s.rem, s.low[31]};
        if (cur >= {1'b0, s.a}) begin
            o.rem = 64'(cur - {1'b0, s.a});
            o.quo = {s.quo[30:0], 1'b1};
        end else begin
            o.rem = cur[63:0];
            o.quo = {s.quo[30:0], 1'b0};
        end
        o.low = {s.low[30:0], 1'b0};
        return o;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NSTEP:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        logic [64:0] nm;
        logic        nn;
        if (i_en) begin
            // Numerator magnitude and sign; it is scaled by 2^16 before dividing.
            if (!i_side.hneg) begin
                nm = {1'b0, i_side.hm} + {1'b0, i_root};
                nn = 1'b1;
            end else if (i_side.hm >= i_root) begin
                nm = {1'b0, i_side.hm - i_root};
                nn = 1'b0;
            end else begin
                nm = {1'b0, i_root - i_side.hm};
                nn = 1'b1;
            end
            // The quotient reaches 2^32 exactly when the scaled numerator
            // shifted down by 32 is at least the divisor.
            r_st[0].ovf    <= {15'h0, nm[64:16]} >= i_side.a;
            r_st[0].rem    <= {15'h0, nm[64:16]};
            r_st[0].low    <= {nm[15:0], 16'h0};
            r_st[0].quo    <= '0;
            r_st[0].nneg   <= nn;
            r_st[0].a      <= i_side.a;
            r_st[0].status <= i_side.status;
            for (int k = 1; k <= NSTEP; k++) begin
                r_st[k] <= step(r_st[k-1]);
            end

            r_status <= r_st[NSTEP].status;
            if (r_st[NSTEP].status != rei_pkg::ST_HIT) begin
                r_hit <= '0;
            end else if (!r_st[NSTEP].nneg) begin
                r_hit <= (r_st[NSTEP].ovf || r_st[NSTEP].quo > 32'h7FFF_FFFF)
                       ? 32'h7FFF_FFFF : r_st[NSTEP].quo;
            end else begin
                r_hit <= (r_st[NSTEP].ovf || r_st[NSTEP].quo > 32'h8000_0000)
                       ? 32'h8000_0000 : -r_st[NSTEP].quo;
            end
        end
    end

    assign o_valid     = r_vld[NSTEP+1];
    assign o_hit_param = r_hit;
    assign o_status    = r_status;

endmodule
`default_nettype wire

/* sv/ray_ellipsoid_intersection.sv */
// Top level: configuration registers, the transform / quadratic / sqrt / divide
// pipeline and an output register with skid. Depends on rei_pkg and the rei_* stages.
//
//  channel   direction  handshake                    payload
//  input     in         i_in_valid / o_in_ready      i_origin_*, i_dir_*
//  result    out        o_out_valid / i_out_ready    o_hit_param, o_status
//  config    in         i_cfg_we                     i_cfg_idx, i_cfg_data
//
// One ray is accepted per cycle while o_in_ready is high; each ray gives one result,
// after the transform, quadratic, 64-stage square root and 32-step divider stages.
// Reset is synchronous and clears the configuration registers and all valid bits.
// The whole pipeline advances together; it halts only while the skid register
// is full, so a stalled result is never lost or repeated.
`default_nettype none
module ray_ellipsoid_intersection (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic signed [31:0]            i_origin_x,
    input  wire logic signed [31:0]            i_origin_y,
    input  wire logic signed [31:0]            i_origin_z,
    input  wire logic signed [31:0]            i_dir_x,
    input  wire logic signed [31:0]            i_dir_y,
    input  wire logic signed [31:0]            i_dir_z,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [31:0]                 o_hit_param,
    output logic [1:0]                         o_status,
    input  wire logic                          i_cfg_we,
    input  wire logic [rei_pkg::IDX_W-1:0]     i_cfg_idx,
    input  wire logic [rei_pkg::CFG_W-1:0]     i_cfg_data
);

    logic [2:0][rei_pkg::CFG_W-1:0] r_rows;
    logic [2:0][31:0]               r_ctr;

    logic                en;
    logic [2:0][31:0]    origin, dir;
    logic                x_vld, q_vld, s_vld, d_vld;
    logic [2:0][31:0]    eo, ed;
    logic [127:0]        disc;
    rei_pkg::t_side      q_side, s_side;
    logic [63:0]         root;
    logic [31:0]         d_hit;
    rei_pkg::t_status    d_status;

    logic                r_out_vld, r_skid_vld;
    logic [31:0]         r_out_hit, r_skid_hit;
    rei_pkg::t_status    r_out_status, r_skid_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= '0;
            r_ctr  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rei_pkg::CFG_ROW_X:    r_rows[0] <= i_cfg_data;
                rei_pkg::CFG_ROW_Y:    r_rows[1] <= i_cfg_data;
                rei_pkg::CFG_ROW_Z:    r_rows[2] <= i_cfg_data;
                rei_pkg::CFG_CENTER_X: r_ctr[0]  <= i_cfg_data[31:0];
                rei_pkg::CFG_CENTER_Y: r_ctr[1]  <= i_cfg_data[31:0];
                rei_pkg::CFG_CENTER_Z: r_ctr[2]  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign en         = !r_skid_vld;
    assign o_in_ready = en;
    assign origin     = {i_origin_z, i_origin_y, i_origin_x};
    assign dir        = {i_dir_z, i_dir_y, i_dir_x};

    rei_xform u_xform (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_in_valid),
        .i_origin (origin),
        .i_dir    (dir),
        .i_rows   (r_rows),
        .i_ctr    (r_ctr),
        .o_valid  (x_vld),
        .o_eo     (eo),
        .o_ed     (ed)
    );

    rei_quad u_quad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (x_vld),
        .i_eo    (eo),
        .i_ed    (ed),
        .o_valid (q_vld),
        .o_disc  (disc),
        .o_side  (q_side)
    );

    rei_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (q_vld),
        .i_disc  (disc),
        .i_side  (q_side),
        .o_valid (s_vld),
        .o_root  (root),
        .o_side  (s_side)
    );

    rei_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (s_vld),
        .i_root      (root),
        .i_side      (s_side),
        .o_valid     (d_vld),
        .o_hit_param (d_hit),
        .o_status    (d_status)
    );

    // A result leaving the pipeline goes to the output register when it is
    // free, otherwise to the skid register, which then halts the pipeline.
    always_ff @(posedge i_clk) begin
        logic take;
        logic arrive;
        take   = r_out_vld && i_out_ready;
        arrive = en && d_vld;
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (!r_out_vld || take) begin
                if (r_skid_vld) begin
                    r_out_vld  <= 1'b1;
                    r_skid_vld <= 1'b0;
                end else begin
                    r_out_vld <= arrive;
                end
            end else if (arrive) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || (r_out_vld && i_out_ready)) begin
            if (r_skid_vld) begin
                r_out_hit    <= r_skid_hit;
                r_out_status <= r_skid_status;
            end else begin
                r_out_hit    <= d_hit;
                r_out_status <= d_status;
            end
        end else if (en && d_vld) begin
            r_skid_hit    <= d_hit;
            r_skid_status <= d_status;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_hit_param = r_out_hit;
    assign o_status    = r_out_status;

endmodule
`default_nettype wire

/* sv/rei_checker.sv */
// Port-level checks for the ray/ellipsoid intersection block, bound to the top.
// Depends on the top-level ports and on rei_pkg for the status codes.
`default_nettype none
module rei_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [31:0] o_hit_param,
    input  wire logic [1:0]  o_status
);

    // Only hits carry a parameter; misses and degenerate rays report zero.
    a_zero_unless_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != rei_pkg::ST_HIT) |-> o_hit_param == 32'h0)
        else $error("non-hit result with nonzero parameter");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == rei_pkg::ST_HIT || o_status == rei_pkg::ST_MISS
                         || o_status == rei_pkg::ST_DEGEN))
        else $error("undefined status code");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_hit_param) && $stable(o_status)))
        else $error("stalled result changed or dropped");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind ray_ellipsoid_intersection rei_checker u_rei_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_hit_param (o_hit_param),
    .o_status    (o_status)
);
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for ray_ellipsoid_intersection: a scoreboard class holds the
// predicted hit parameter and status for each ray, and plain tasks drive both channels.
// Depends on rei_pkg for the register indexes and the status codes.
`default_nettype none
module testbench;

    typedef struct {
        logic signed [31:0] hit_param;
        rei_pkg::t_status   status;
    } t_ray_result;

    class ray_scoreboard;
        t_ray_result pending_q[$];
        int          errors;
        int          checked;

        function void note_ray(t_ray_result r);
            pending_q.push_back(r);
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_result(logic signed [31:0] hit_param, logic [1:0] status);
            t_ray_result exp_r;
            if (pending_q.size() == 0) begin
                report($sformatf("result with nothing pending: t=%h status=%0d",
                                 hit_param, status));
            end else begin
                exp_r = pending_q.pop_front();
                checked++;
                if (status !== exp_r.status)
                    report($sformatf("status got %0d expected %0d (result %0d)",
                                     status, exp_r.status, checked));
                if (hit_param !== exp_r.hit_param)
                    report($sformatf("hit_param got %h expected %h (result %0d)",
                                     hit_param, exp_r.hit_param, checked));
            end
        endtask
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic signed [31:0]            i_origin_x, i_origin_y, i_origin_z;
    logic signed [31:0]            i_dir_x, i_dir_y, i_dir_z;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic signed [31:0]            o_hit_param;
    logic [1:0]                    o_status;
    logic                          i_cfg_we;
    logic [rei_pkg::IDX_W-1:0]     i_cfg_idx;
    logic [rei_pkg::CFG_W-1:0]     i_cfg_data;

    ray_ellipsoid_intersection u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_origin_x (i_origin_x),
        .i_origin_y (i_origin_y),
        .i_origin_z (i_origin_z),
        .i_dir_x    (i_dir_x),
        .i_dir_y    (i_dir_y),
        .i_dir_z    (i_dir_z),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_hit_param(o_hit_param),
        .o_status   (o_status),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    ray_scoreboard sb = new();

    // Local copy of the ellipsoid registers.
    logic [62:0] row_copy[3];
    logic [31:0] center_copy[3];

    bit burst_mode;
    int rays_sent;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("timeout");
        $display("testbench: done, errors");
        $finish;
    end

    function automatic longint sat_q16(longint v);
        longint r;
        r = (v + 32768) >>> 16;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r;
    endfunction

    function automatic t_ray_result predict_hit(
        logic signed [31:0] ox, logic signed [31:0] oy, logic signed [31:0] oz,
        logic signed [31:0] dx, logic signed [31:0] dy, logic signed [31:0] dz);
        longint       rel[3], dv[3], eo[3], ed[3];
        longint       so, sd, m, p;
        logic [63:0]  a, q, pos, neg, hm, cm, s, cand;
        logic [127:0] hsq, ac, disc, nm, qt;
        bit           hneg, cneg, nneg;
        t_ray_result  r;
        rel[0] = longint'(ox) - longint'($signed(center_copy[0]));
        rel[1] = longint'(oy) - longint'($signed(center_copy[1]));
        rel[2] = longint'(oz) - longint'($signed(center_copy[2]));
        dv[0] = longint'(dx);
        dv[1] = longint'(dy);
        dv[2] = longint'(dz);
        for (int i = 0; i < 3; i++) begin
            so = 0;
            sd = 0;
            for (int j = 0; j < 3; j++) begin
                m = longint'($signed(row_copy[i][21*j +: 21]));
                so += rel[j] * m;
                sd += dv[j] * m;
            end
            eo[i] = sat_q16(so);
            ed[i] = sat_q16(sd);
        end
        a = 0; q = 0; pos = 0; neg = 0;
        for (int i = 0; i < 3; i++) begin
            p = eo[i] * ed[i];
            a += 64'(ed[i] * ed[i]);
            q += 64'(eo[i] * eo[i]);
            if (p >= 0) pos += 64'(p);
            else neg += 64'(-p);
        end
        r.hit_param = 32'sd0;
        if (a == 0) begin
            r.status = rei_pkg::ST_DEGEN;
            return r;
        end
        hneg = pos < neg;
        hm = hneg ? neg - pos : pos - neg;
        cneg = q < rei_pkg::ONE_Q32;
        cm = cneg ? rei_pkg::ONE_Q32 - q : q - rei_pkg::ONE_Q32;
        hsq = {64'd0, hm} * {64'd0, hm};
        ac = {64'd0, a} * {64'd0, cm};
        if (cneg) begin
            disc = hsq + ac;
        end else begin
            if (hsq < ac) begin
                r.status = rei_pkg::ST_MISS;
                return r;
            end
            disc = hsq - ac;
        end
        s = 0;
        for (int b = 63; b >= 0; b--) begin
            cand = s | (64'd1 << b);
            if ({64'd0, cand} * {64'd0, cand} <= disc) s = cand;
        end
        if (!hneg) begin
            nneg = 1'b1;
            nm = {64'd0, hm} + {64'd0, s};
        end else if (hm >= s) begin
            nneg = 1'b0;
            nm = {64'd0, hm - s};
        end else begin
            nneg = 1'b1;
            nm = {64'd0, s - hm};
        end
        nm = nm << 16;
        qt = nm / {64'd0, a};
        if (!nneg)
            r.hit_param = (qt > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : qt[31:0];
        else
            r.hit_param = (qt > 128'h8000_0000) ? 32'h8000_0000 : -qt[31:0];
        r.status = rei_pkg::ST_HIT;
        return r;
    endfunction

    // Transfers on both channels are seen here, on the values present before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.note_ray(predict_hit(i_origin_x, i_origin_y, i_origin_z,
                                        i_dir_x, i_dir_y, i_dir_z));
            if (o_out_valid && i_out_ready)
                sb.check_result(o_hit_param, o_status);
        end
    end

    function automatic int draw_gap();
        if (burst_mode) return 0;
        return $urandom_range(0, 16);
    endfunction

    // Result side: ready drops for a random gap, possibly none, before each transfer.
    initial begin
        int w;
        i_out_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            w = draw_gap();
            if (w > 0) begin
                i_out_ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    task automatic send_ray(logic signed [31:0] ox, logic signed [31:0] oy,
                            logic signed [31:0] oz, logic signed [31:0] dx,
                            logic signed [31:0] dy, logic signed [31:0] dz);
        int w;
        w = draw_gap();
        if (w > 0) begin
            i_in_valid <= 1'b0;
            repeat (w) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_origin_x <= ox;
        i_origin_y <= oy;
        i_origin_z <= oz;
        i_dir_x    <= dx;
        i_dir_y    <= dy;
        i_dir_z    <= dz;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        rays_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    // The write enable stays high across a run of writes; setup_phase drops it.
    task automatic write_reg(logic [rei_pkg::IDX_W-1:0] idx,
                             logic [rei_pkg::CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx <= rei_pkg::CFG_ROW_Z)
            row_copy[2'(idx)] = data;
        else if (idx <= rei_pkg::CFG_CENTER_Z)
            center_copy[2'(idx - rei_pkg::CFG_CENTER_X)] = data[31:0];
    endtask

    function automatic logic [62:0] pack_row(int ex, int ey, int ez);
        return {ez[20:0], ey[20:0], ex[20:0]};
    endfunction

    function automatic int signed_draw(int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    task automatic write_center(int cx, int cy, int cz);
        write_reg(rei_pkg::CFG_CENTER_X, (rei_pkg::CFG_W)'(unsigned'(cx)));
        write_reg(rei_pkg::CFG_CENTER_Y, (rei_pkg::CFG_W)'(unsigned'(cy)));
        write_reg(rei_pkg::CFG_CENTER_Z, (rei_pkg::CFG_W)'(unsigned'(cz)));
    endtask

    task automatic setup_phase(int ph);
        int e[9];
        case (ph)
            1: begin
                write_reg(rei_pkg::CFG_ROW_X, pack_row(65536, 0, 0));
                write_reg(rei_pkg::CFG_ROW_Y, pack_row(0, 65536, 0));
                write_reg(rei_pkg::CFG_ROW_Z, pack_row(0, 0, 65536));
                write_center(0, 0, 0);
            end
            2: begin
                write_reg(rei_pkg::CFG_ROW_X, pack_row(65536 / $urandom_range(1, 8), 0, 0));
                write_reg(rei_pkg::CFG_ROW_Y, pack_row(0, 65536 / $urandom_range(1, 8), 0));
                write_reg(rei_pkg::CFG_ROW_Z, pack_row(0, 0, 65536 / $urandom_range(1, 8)));
                write_center(signed_draw(100 << 16), signed_draw(100 << 16),
                             signed_draw(100 << 16));
            end
            3: begin
                foreach (e[k]) e[k] = signed_draw(65536);
                write_reg(rei_pkg::CFG_ROW_X, pack_row(e[0], e[1], e[2]));
                write_reg(rei_pkg::CFG_ROW_Y, pack_row(e[3], e[4], e[5]));
                write_reg(rei_pkg::CFG_ROW_Z, pack_row(e[6], e[7], e[8]));
                write_center(signed_draw(1000 << 16), signed_draw(1000 << 16),
                             signed_draw(1000 << 16));
            end
            4: begin
                // Largest and most negative matrix entries with the centre at its limits.
                write_reg(rei_pkg::CFG_ROW_X, pack_row(32'h0F_FFFF, 32'h10_0000, 32'h0F_FFFF));
                write_reg(rei_pkg::CFG_ROW_Y, pack_row(32'h10_0000, 32'h0F_FFFF, 32'h10_0000));
                write_reg(rei_pkg::CFG_ROW_Z, pack_row(32'h0F_FFFF, 32'h0F_FFFF, 32'h10_0000));
                write_center(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
                // Indexes past the register list must leave everything alone.
                write_reg(3'd6, (rei_pkg::CFG_W)'({$urandom, $urandom}));
                write_reg(3'd7, (rei_pkg::CFG_W)'({$urandom, $urandom}));
            end
            default: begin
                write_reg(rei_pkg::CFG_ROW_X, (rei_pkg::CFG_W)'({$urandom, $urandom}));
                write_reg(rei_pkg::CFG_ROW_Y, (rei_pkg::CFG_W)'({$urandom, $urandom}));
                write_reg(rei_pkg::CFG_ROW_Z, (rei_pkg::CFG_W)'({$urandom, $urandom}));
                write_center($urandom, $urandom, $urandom);
            end
        endcase
        i_cfg_we <= 1'b0;
    endtask

    // Mostly rays aimed near the centre, so that hits and near misses dominate.
    task automatic random_ray();
        int off[3], dv[3], sh;
        if ($urandom_range(0, 3) == 0) begin
            send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            sh = $urandom_range(0, 4);
            foreach (off[k]) begin
                off[k] = signed_draw(8 << 16);
                dv[k] = (signed_draw(1 << 16) - off[k]) >>> sh;
            end
            send_ray($signed(center_copy[0]) + off[0], $signed(center_copy[1]) + off[1],
                     $signed(center_copy[2]) + off[2], dv[0], dv[1], dv[2]);
        end
    endtask

    localparam int ONE = 65536;

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_origin_x = '0; i_origin_y = '0; i_origin_z = '0;
        i_dir_x    = '0; i_dir_y    = '0; i_dir_z    = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        foreach (row_copy[k]) row_copy[k] = '0;
        foreach (center_copy[k]) center_copy[k] = '0;
        burst_mode = 1'b0;
        rays_sent  = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // All-zero matrix after reset: every ray is degenerate.
        repeat (20) random_ray();
        wait_idle();

        setup_phase(1);
        send_ray(-3 * ONE, 0, 0, ONE, 0, 0);               // plain hit at t = 2
        send_ray(0, 0, 0, 0, 0, ONE);                      // origin inside, negative t
        send_ray(0, 5 * ONE, 0, ONE, 0, 0);                // miss
        send_ray(ONE, ONE, ONE, 0, 0, 0);                  // zero direction
        send_ray(-10 * ONE, 0, 0, 1, 0, 0);                // tiny direction, t saturates
        send_ray(10 * ONE, 0, 0, -1, 0, 0);
        send_ray(0, 0, 0, 1, 0, 0);                        // inside, t saturates negative
        send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_ray(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0);
        send_ray(-ONE, 0, 0, ONE, 0, 0);                   // origin on the surface
        send_ray(0, -2 * ONE, 0, 0, ONE, 0);
        send_ray(0, 0, 3 * ONE, 0, 0, -2 * ONE);
        send_ray(-2 * ONE, ONE, 0, ONE, 0, 0);             // tangent
        send_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1);
        send_ray(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);

        for (int ph = 1; ph <= 6; ph++) begin
            if (ph > 1) begin
                wait_idle();
                setup_phase(ph);
            end
            for (int n = 0; n < 300; n++) begin
                if (n % 100 == 0) burst_mode = ($urandom_range(0, 2) == 0);
                random_ray();
            end
            burst_mode = 1'b0;
        end

        wait_idle();
        if (sb.pending_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending_q.size()));
        $display("covered %0d rays over zero, unit, scaled, rotated, extreme and random",
                 rays_sent);
        $display("ellipsoid settings; %0d results checked", sb.checked);
        if (sb.errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
